// ----- rtl/core/arsa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Audio RAM stream accelerator package
// Shared constants, codes and field types for the stream accelerator.
// ----------------------------------------------------------------------------
package arsa_pkg;

   // Byte store geometry. The store is kept as rows of two bytes, even byte
   // in the upper half of a row.
   localparam int unsigned STORE_BYTES = 65536;
   localparam int unsigned IDX_W       = $clog2(STORE_BYTES);
   localparam int unsigned ROW_W       = IDX_W - 1;
   localparam int unsigned STORE_ROWS  = STORE_BYTES / 2;

   localparam int unsigned ADDR_W  = 27;
   localparam int unsigned DIR_BIT = 31;

   typedef logic [1:0]  mode_type;
   typedef logic [1:0]  err_type;
   typedef logic [1:0]  irq_kind_type;
   typedef logic [1:0]  csr_index_type;
   typedef logic [1:0]  size_type;
   typedef logic [4:0]  format_type;
   typedef logic [31:0] addr_type;

   localparam mode_type MODE_READ  = 2'd0;
   localparam mode_type MODE_WRITE = 2'd1;
   localparam mode_type MODE_LOAD  = 2'd2;

   localparam err_type ERR_NONE      = 2'd0;
   localparam err_type ERR_DIRECTION = 2'd1;
   localparam err_type ERR_FORMAT    = 2'd2;

   localparam irq_kind_type IRQ_DECODER_END = 2'd0;
   localparam irq_kind_type IRQ_READ_END    = 2'd1;
   localparam irq_kind_type IRQ_WRITE_END   = 2'd2;

   localparam csr_index_type CSR_SAMPLE_FORMAT = 2'd0;
   localparam csr_index_type CSR_START_ADDRESS = 2'd1;
   localparam csr_index_type CSR_END_ADDRESS   = 2'd2;

   localparam size_type SIZE_4BIT  = 2'd0;
   localparam size_type SIZE_8BIT  = 2'd1;
   localparam size_type SIZE_16BIT = 2'd2;
   localparam size_type SIZE_BAD   = 2'd3;

endpackage

// ----- rtl/core/audio_ram_stream_accelerator_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Audio RAM stream accelerator
// Byte store with a streaming current address: nibble, byte and halfword
// reads with ADPCM pred/scale refresh, halfword writes, wrap interrupts.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake                 | Payload
//  --------+-----------+---------------------------+--------------------------
//  req_    | in        | req_valid / req_ready     | mode, write_data, new_address
//  rsp_    | out       | rsp_valid / rsp_ready     | read_data ... error_code
//  csr_    | in        | csr_write_enable          | csr_index, csr_write_data
//
// One transaction at a time: a load, write or error passes through accept
// (IDLE) and execute (EXEC), a plain read also through SAMPLE, and a read with
// pred/scale refresh through PRED then SAMPLE, one state more per store read;
// the result enters the output register as the last state ends. After reset
// the store is zeroed one row per cycle, all 32768 rows, while req_ready stays
// low. A waiting result stalls only the final state of the next transaction.
//
module audio_ram_stream_accelerator_top (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  arsa_pkg::mode_type      req_mode,
   input  logic [15:0]             req_write_data,
   input  arsa_pkg::addr_type      req_new_address,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [15:0]             rsp_read_data,
   output logic [7:0]              rsp_pred_scale,
   output arsa_pkg::addr_type      rsp_address_now,
   output logic                    rsp_irq_raised,
   output arsa_pkg::irq_kind_type  rsp_irq_kind,
   output arsa_pkg::err_type       rsp_error_code,
   input  logic                    csr_write_enable,
   input  arsa_pkg::csr_index_type csr_index,
   input  logic [31:0]             csr_write_data
);
   import arsa_pkg::*;

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_EXEC   = 3'd2;
   localparam logic [2:0] ST_PRED   = 3'd3;
   localparam logic [2:0] ST_SAMPLE = 3'd4;

   // Configuration registers
   format_type          format_ff;
   addr_type            start_ff;
   logic [ADDR_W-1:0]   end_ff;

   // Control and state
   logic [2:0]          state_ff, state_in;
   logic [ROW_W-1:0]    clear_cnt_ff, clear_cnt_in;
   addr_type            addr_ff, addr_in;
   logic [7:0]          pred_ff, pred_in;

   // Captured transaction
   mode_type            mode_ff;
   logic [15:0]         wdata_ff;
   addr_type            naddr_ff;

   // Output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [15:0]         rsp_rdata_ff;
   logic [7:0]          rsp_pred_ff;
   addr_type            rsp_addr_ff;
   logic                rsp_irq_ff;
   irq_kind_type        rsp_kind_ff;
   err_type             rsp_err_ff;

   // Store
   logic [15:0]         store_mem [STORE_ROWS];
   logic [15:0]         rd_ff;
   logic                mem_we, mem_re;
   logic [ROW_W-1:0]    mem_waddr, mem_raddr;
   logic [15:0]         mem_wdata;

   // Result of the finishing cycle
   logic                finish;
   logic [15:0]         f_rdata;
   logic                f_irq;
   irq_kind_type        f_kind;
   err_type             f_err;
   logic                out_free;
   logic [32:0]         adv_res;
   logic [7:0]          smp_byte;
   size_type            size;
   logic                pred_need;

   function automatic logic [ROW_W-1:0] sample_row(input addr_type a, input size_type s);
      logic [ROW_W-1:0] r;
      case (s)
         SIZE_4BIT:  r = a[IDX_W:2];
         SIZE_8BIT:  r = a[IDX_W-1:1];
         default:    r = a[ROW_W-1:0];
      endcase
      return r;
   endfunction

   function automatic logic sample_odd(input addr_type a, input size_type s);
      logic o;
      case (s)
         SIZE_4BIT:  o = a[1];
         SIZE_8BIT:  o = a[0];
         default:    o = 1'b0;
      endcase
      return o;
   endfunction

   // Returns {wrap, next address}: step by one, reload on reaching the end.
   function automatic logic [32:0] advance(input addr_type a, input addr_type start,
                                           input logic [ADDR_W-1:0] end_addr);
      addr_type nxt;
      logic     wrap;
      nxt  = a + 32'd1;
      wrap = nxt[ADDR_W-1:0] >= end_addr;
      return {wrap, wrap ? start : nxt};
   endfunction

   assign size      = format_ff[1:0];
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign pred_need = (size == SIZE_4BIT) && (addr_ff[3:0] == 4'h0) &&
                      (format_ff[3:2] == 2'b00);
   assign smp_byte  = sample_odd(addr_ff, size) ? rd_ff[7:0] : rd_ff[15:8];

   always_comb begin
      state_in     = state_ff;
      clear_cnt_in = clear_cnt_ff;
      addr_in      = addr_ff;
      pred_in      = pred_ff;
      mem_we       = 1'b0;
      mem_waddr    = clear_cnt_ff;
      mem_wdata    = '0;
      mem_re       = 1'b0;
      mem_raddr    = sample_row(addr_ff, size);
      finish       = 1'b0;
      f_rdata      = '0;
      f_irq        = 1'b0;
      f_kind       = IRQ_DECODER_END;
      f_err        = ERR_NONE;
      adv_res      = advance(addr_ff, start_ff, end_ff);
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we       = 1'b1;
            clear_cnt_in = clear_cnt_ff + 1'b1;
            if (&clear_cnt_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (mode_ff)
               MODE_READ: begin
                  if (addr_ff[DIR_BIT] || size == SIZE_BAD) begin
                     if (out_free) begin
                        finish   = 1'b1;
                        f_err    = addr_ff[DIR_BIT] ? ERR_DIRECTION : ERR_FORMAT;
                        state_in = ST_IDLE;
                     end
                  end else if (pred_need) begin
                     // The pred/scale byte sits at an even byte of its row.
                     mem_re    = 1'b1;
                     mem_raddr = addr_ff[IDX_W:2];
                     addr_in   = addr_ff + 32'd2;
                     state_in  = ST_PRED;
                  end else begin
                     mem_re   = 1'b1;
                     state_in = ST_SAMPLE;
                  end
               end
               MODE_WRITE: begin
                  if (out_free) begin
                     finish   = 1'b1;
                     state_in = ST_IDLE;
                     if (!addr_ff[DIR_BIT]) begin
                        f_err = ERR_DIRECTION;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = addr_ff[ROW_W-1:0];
                        mem_wdata = wdata_ff;
                        addr_in   = adv_res[31:0];
                        if (adv_res[32]) begin
                           addr_in[DIR_BIT] = 1'b1;
                           f_irq            = 1'b1;
                           f_kind           = IRQ_WRITE_END;
                        end
                     end
                  end
               end
               MODE_LOAD: begin
                  if (out_free) begin
                     finish   = 1'b1;
                     addr_in  = naddr_ff;
                     state_in = ST_IDLE;
                  end
               end
               default: begin
                  if (out_free) begin
                     finish   = 1'b1;
                     state_in = ST_IDLE;
                  end
               end
            endcase
         end
         ST_PRED: begin
            pred_in  = rd_ff[15:8];
            mem_re   = 1'b1;
            state_in = ST_SAMPLE;
         end
         ST_SAMPLE: begin
            if (out_free) begin
               finish   = 1'b1;
               state_in = ST_IDLE;
               case (size)
                  SIZE_4BIT: f_rdata = {12'h000, addr_ff[0] ? smp_byte[3:0] : smp_byte[7:4]};
                  SIZE_8BIT: f_rdata = {8'h00, smp_byte};
                  default:   f_rdata = rd_ff;
               endcase
               addr_in = adv_res[31:0];
               if (adv_res[32]) begin
                  f_irq  = 1'b1;
                  f_kind = (format_ff[4:3] == 2'b00) ? IRQ_DECODER_END : IRQ_READ_END;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_cnt_ff <= '0;
         addr_ff      <= '0;
         pred_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         format_ff    <= '0;
         start_ff     <= '0;
         end_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         clear_cnt_ff <= clear_cnt_in;
         addr_ff      <= addr_in;
         pred_ff      <= pred_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_SAMPLE_FORMAT: format_ff <= csr_write_data[4:0];
               CSR_START_ADDRESS: start_ff  <= csr_write_data;
               CSR_END_ADDRESS:   end_ff    <= csr_write_data[ADDR_W-1:0];
               default:           ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         mode_ff  <= req_mode;
         wdata_ff <= req_write_data;
         naddr_ff <= req_new_address;
      end
      if (finish) begin
         rsp_rdata_ff <= f_rdata;
         rsp_pred_ff  <= pred_in;
         rsp_addr_ff  <= addr_in;
         rsp_irq_ff   <= f_irq;
         rsp_kind_ff  <= f_kind;
         rsp_err_ff   <= f_err;
      end
   end

   // Store: one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_ff <= store_mem[mem_raddr];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_data   = rsp_rdata_ff;
   assign rsp_pred_scale  = rsp_pred_ff;
   assign rsp_address_now = rsp_addr_ff;
   assign rsp_irq_raised  = rsp_irq_ff;
   assign rsp_irq_kind    = rsp_kind_ff;
   assign rsp_error_code  = rsp_err_ff;

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_EXEC)
      else $error("accepted transaction did not enter execution");

   a_irq_no_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_irq_raised |-> rsp_error_code == ERR_NONE)
      else $error("interrupt raised together with an error");

   a_write_wrap_dir: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_irq_raised && rsp_irq_kind == IRQ_WRITE_END |-> rsp_address_now[DIR_BIT])
      else $error("write wrap left the direction bit clear");

   a_err_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code != ERR_NONE |-> rsp_read_data == 16'h0000)
      else $error("error result carries read data");

   a_pred_then_sample: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PRED |=> state_ff == ST_SAMPLE && $past(mem_re))
      else $error("pred/scale fetch not followed by the sample fetch");

endmodule
